// ===== rtl/vcq_pkg.sv =====
// vcq_pkg: shared types and constants for the virtqueue block request engine
// no dependencies; imported by the top level and the testbench
package vcq_pkg;

    // queue geometry, fixed by the 3-bit descriptor index fields
    localparam int RING_ENTRIES     = 8;
    localparam int IDX_W            = $clog2(RING_ENTRIES);
    localparam int PEND_CNT_W       = IDX_W + 1;
    localparam int CHAIN_LEN        = 3;

    // default block size in bytes
    localparam int BLOCK_BYTES_DEF  = 1024;
    localparam int SECTOR_BYTES     = 512;
    localparam int HDR_BYTES        = 16;

    // configuration port
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BASE   = 2'd0,
        CFG_HEADER_STRIDE = 2'd1,
        CFG_STATUS_BASE   = 2'd2,
        CFG_STATUS_STRIDE = 2'd3
    } cfg_index_t;

    // descriptor flags
    localparam logic [1:0] F_NEXT  = 2'b01;
    localparam logic [1:0] F_DEVWR = 2'b10;

    // result word kinds
    typedef enum logic [3:0] {
        KIND_DESC       = 4'd0,
        KIND_HEADER     = 4'd1,
        KIND_STATUS     = 4'd2,
        KIND_AVAIL      = 4'd3,
        KIND_NOTIFY     = 4'd4,
        KIND_OK         = 4'd5,
        KIND_NO_FREE    = 4'd6,
        KIND_UNEXPECTED = 4'd7,
        KIND_IO_ERROR   = 4'd8
    } kind_t;

    // input item kinds
    localparam logic REQ_SUBMIT   = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SUB      = 3'd1,
        ST_CMP_HEAD = 3'd2,
        ST_WALK     = 3'd3,
        ST_REPLY    = 3'd4
    } state_t;

    // order of the words of one submission
    typedef enum logic [2:0] {
        STEP_HEADER      = 3'd0,
        STEP_DESC_HEAD   = 3'd1,
        STEP_DESC_DATA   = 3'd2,
        STEP_DESC_STATUS = 3'd3,
        STEP_STATUS      = 3'd4,
        STEP_AVAIL       = 3'd5,
        STEP_NOTIFY      = 3'd6
    } step_t;

    // one stored chain link
    typedef struct packed {
        logic [1:0]       flags;
        logic [IDX_W-1:0] next;
    } chain_entry_t;

endpackage

// ===== rtl/vcq_ram.sv =====
// vcq_ram: generic single-write, single-read memory with registered read data
// no dependencies
module vcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/virtqueue_block_request_engine.sv =====
// virtqueue_block_request_engine: driver side of a virtio block split virtqueue
// depends on vcq_pkg and vcq_ram (chain link memory, outstanding head memory)
//
// Usage
//   Input channel (in_valid/in_ready) carries one item: req_type 0 submits a
//   block request, req_type 1 reports a completion read from the used ring.
//   Output channel (out_valid/out_ready) carries result words; last marks the
//   final word of an item. Configuration writes (cfg_wr_en, cfg_index,
//   cfg_data) take effect at once and are meant for when the block is idle.
//   A submission yields seven words (header, three descriptors, status preset,
//   avail write, notify) or a single no-free word. A completion yields one
//   word: ok, io error or unexpected.
//   Flow: one item at a time; in_ready is low from accept until the item's
//   last word is loaded. With no stall a submission sends its words one a
//   cycle through the output register, header first and notify last, and the
//   next item can be taken once the notify word is loaded. A completion reads
//   the outstanding head, then frees its chain one link at a time (three
//   links) and then sends its reply. A no-free reply goes out straight after
//   accept; an unexpected one follows the outstanding head read.
//   A stall on out_ready holds the current word and pauses the sequencer.
//   Reset empties the queue: all descriptors free, indices and counts zero,
//   strides 16, bases 0. No memory clearing pass is needed.
module virtqueue_block_request_engine #(
    parameter int BLOCK_BYTES = vcq_pkg::BLOCK_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [vcq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vcq_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic                            write_req,
    input  logic [31:0]                     block_number,
    input  logic [63:0]                     data_addr,
    input  logic [31:0]                     used_id,
    input  logic [7:0]                      io_status,
    // result words
    output logic                            out_valid,
    input  logic                            out_ready,
    output vcq_pkg::kind_t                  out_kind,
    output logic [vcq_pkg::IDX_W-1:0]       desc_index,
    output logic [63:0]                     addr,
    output logic [31:0]                     length,
    output logic [1:0]                      flags,
    output logic [vcq_pkg::IDX_W-1:0]       next_index,
    output logic                            header_type,
    output logic [63:0]                     sector,
    output logic [vcq_pkg::IDX_W-1:0]       ring_slot,
    output logic [15:0]                     ring_index,
    output logic                            last
);

    import vcq_pkg::*;

    localparam int SECT_PER_BLK = BLOCK_BYTES / SECTOR_BYTES;
    localparam int CHAIN_W      = $bits(chain_entry_t);

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] desc_index;
        logic [63:0]      addr;
        logic [31:0]      length;
        logic [1:0]       flags;
        logic [IDX_W-1:0] next_index;
        logic             header_type;
        logic [63:0]      sector;
        logic [IDX_W-1:0] ring_slot;
        logic [15:0]      ring_index;
        logic             last;
    } out_word_t;

    // configuration registers
    logic [63:0] header_base_reg;
    logic [7:0]  header_stride_reg;
    logic [63:0] status_base_reg;
    logic [7:0]  status_stride_reg;

    // control state
    state_t                 state_reg, state_next;
    step_t                  step_reg;
    logic [RING_ENTRIES-1:0] free_map_reg;
    logic [15:0]            avail_reg;
    logic [PEND_CNT_W-1:0]  pend_total_reg;
    logic [IDX_W-1:0]       pend_rptr_reg;
    logic [IDX_W-1:0]       pend_wptr_reg;
    logic [IDX_W-1:0]       steps_reg;

    // item payload held during processing
    logic             wr_reg;
    logic [63:0]      data_addr_reg;
    logic [31:0]      used_id_reg;
    logic             io_err_reg;
    logic [IDX_W-1:0] d0_reg, d1_reg, d2_reg;
    logic [63:0]      haddr_reg, saddr_reg, sector_reg;
    logic [IDX_W-1:0] head_reg, cur_reg;
    kind_t            reply_kind_reg;
    logic [IDX_W-1:0] reply_di_reg;

    // output stage
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t gen_word;
    logic      gen_valid;
    logic      out_load;

    // memory ports
    logic             chain_we;
    logic [IDX_W-1:0] chain_waddr, chain_raddr;
    chain_entry_t     chain_wdata, chain_rdata;
    logic             pend_we;
    logic [IDX_W-1:0] pend_rdata;

    logic             in_fire;
    logic             alloc_ok;
    logic [1:0]       alloc_n;
    logic [IDX_W-1:0] alloc_d0, alloc_d1, alloc_d2;
    logic [1:0]       data_flags;
    logic             walk_end;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = gen_valid && (!out_valid_reg || out_ready);
    assign data_flags = F_NEXT | (wr_reg ? 2'b00 : F_DEVWR);
    assign walk_end  = !chain_rdata.flags[0] || (steps_reg == IDX_W'(RING_ENTRIES - 1));

    // lowest three free descriptors
    always_comb
    begin
        alloc_n  = 2'd0;
        alloc_d0 = '0;
        alloc_d1 = '0;
        alloc_d2 = '0;
        for (int i = 0; i < RING_ENTRIES; i++)
        begin
            if (free_map_reg[i] && alloc_n != 2'd3)
            begin
                case (alloc_n)
                    2'd0:    alloc_d0 = IDX_W'(i);
                    2'd1:    alloc_d1 = IDX_W'(i);
                    default: alloc_d2 = IDX_W'(i);
                endcase
                alloc_n = alloc_n + 2'd1;
            end
        end
        alloc_ok = (alloc_n == 2'd3) && (pend_total_reg < PEND_CNT_W'(RING_ENTRIES));
    end

    // chain links: descriptor index -> flags and next
    vcq_ram #(
        .WIDTH (CHAIN_W),
        .DEPTH (RING_ENTRIES)
    ) u_chain_ram (
        .clk   (clk),
        .we    (chain_we),
        .waddr (chain_waddr),
        .wdata (chain_wdata),
        .raddr (chain_raddr),
        .rdata (chain_rdata)
    );

    // outstanding heads, oldest at the read pointer
    vcq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (RING_ENTRIES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_wptr_reg),
        .wdata (alloc_d0),
        .raddr (pend_rptr_reg),
        .rdata (pend_rdata)
    );

    assign pend_we = in_fire && (req_type == REQ_SUBMIT) && alloc_ok;

    // chain memory write while the descriptor words go out
    always_comb
    begin
        chain_we    = 1'b0;
        chain_waddr = d0_reg;
        chain_wdata = '{flags: F_NEXT, next: d1_reg};
        if (state_reg == ST_SUB && out_load)
        begin
            case (step_reg)
                STEP_DESC_HEAD:
                begin
                    chain_we    = 1'b1;
                    chain_waddr = d0_reg;
                    chain_wdata = '{flags: F_NEXT, next: d1_reg};
                end
                STEP_DESC_DATA:
                begin
                    chain_we    = 1'b1;
                    chain_waddr = d1_reg;
                    chain_wdata = '{flags: data_flags, next: d2_reg};
                end
                STEP_DESC_STATUS:
                begin
                    chain_we    = 1'b1;
                    chain_waddr = d2_reg;
                    chain_wdata = '{flags: F_DEVWR, next: '0};
                end
                default:
                begin
                    chain_we = 1'b0;
                end
            endcase
        end
    end

    // chain read address follows the walk
    always_comb
    begin
        case (state_reg)
            ST_CMP_HEAD: chain_raddr = pend_rdata;
            ST_WALK:     chain_raddr = chain_rdata.next;
            default:     chain_raddr = cur_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_COMPLETE)
                        state_next = ST_CMP_HEAD;
                    else if (alloc_ok)
                        state_next = ST_SUB;
                    else
                        state_next = ST_REPLY;
                end
            end
            ST_SUB:
            begin
                if (out_load && step_reg == STEP_NOTIFY)
                    state_next = ST_IDLE;
            end
            ST_CMP_HEAD:
            begin
                if (pend_total_reg == '0 || used_id_reg != 32'(pend_rdata))
                    state_next = ST_REPLY;
                else
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_end)
                    state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // word generator
    always_comb
    begin
        gen_word  = '0;
        gen_valid = 1'b0;
        case (state_reg)
            ST_SUB:
            begin
                gen_valid           = 1'b1;
                gen_word.desc_index = d0_reg;
                case (step_reg)
                    STEP_HEADER:
                    begin
                        gen_word.kind        = KIND_HEADER;
                        gen_word.addr        = haddr_reg;
                        gen_word.header_type = wr_reg;
                        gen_word.sector      = sector_reg;
                    end
                    STEP_DESC_HEAD:
                    begin
                        gen_word.kind       = KIND_DESC;
                        gen_word.addr       = haddr_reg;
                        gen_word.length     = 32'(HDR_BYTES);
                        gen_word.flags      = F_NEXT;
                        gen_word.next_index = d1_reg;
                    end
                    STEP_DESC_DATA:
                    begin
                        gen_word.kind       = KIND_DESC;
                        gen_word.desc_index = d1_reg;
                        gen_word.addr       = data_addr_reg;
                        gen_word.length     = 32'(BLOCK_BYTES);
                        gen_word.flags      = data_flags;
                        gen_word.next_index = d2_reg;
                    end
                    STEP_DESC_STATUS:
                    begin
                        gen_word.kind       = KIND_DESC;
                        gen_word.desc_index = d2_reg;
                        gen_word.addr       = saddr_reg;
                        gen_word.length     = 32'd1;
                        gen_word.flags      = F_DEVWR;
                    end
                    STEP_STATUS:
                    begin
                        gen_word.kind = KIND_STATUS;
                        gen_word.addr = saddr_reg;
                    end
                    STEP_AVAIL:
                    begin
                        gen_word.kind       = KIND_AVAIL;
                        gen_word.ring_slot  = IDX_W'(avail_reg - 16'd1);
                        gen_word.ring_index = avail_reg;
                    end
                    default:
                    begin
                        gen_word.kind = KIND_NOTIFY;
                        gen_word.last = 1'b1;
                    end
                endcase
            end
            ST_REPLY:
            begin
                gen_valid           = 1'b1;
                gen_word.kind       = reply_kind_reg;
                gen_word.desc_index = reply_di_reg;
                gen_word.last       = 1'b1;
            end
            default:
            begin
                gen_valid = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_base_reg   <= '0;
            header_stride_reg <= 8'd16;
            status_base_reg   <= '0;
            status_stride_reg <= 8'd16;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HEADER_BASE:   header_base_reg   <= cfg_data;
                CFG_HEADER_STRIDE: header_stride_reg <= cfg_data[7:0];
                CFG_STATUS_BASE:   status_base_reg   <= cfg_data;
                CFG_STATUS_STRIDE: status_stride_reg <= cfg_data[7:0];
                default:           header_base_reg   <= header_base_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_HEADER;
            free_map_reg   <= '1;
            avail_reg      <= '0;
            pend_total_reg <= '0;
            pend_rptr_reg  <= '0;
            pend_wptr_reg  <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // submission takes its descriptors at accept
            if (pend_we)
            begin
                free_map_reg[alloc_d0] <= 1'b0;
                free_map_reg[alloc_d1] <= 1'b0;
                free_map_reg[alloc_d2] <= 1'b0;
                avail_reg              <= avail_reg + 16'd1;
                pend_wptr_reg          <= pend_wptr_reg + IDX_W'(1);
                pend_total_reg         <= pend_total_reg + PEND_CNT_W'(1);
                step_reg               <= STEP_HEADER;
            end
            // word sequence of a submission
            if (state_reg == ST_SUB && out_load)
            begin
                step_reg <= step_t'(3'(step_reg) + 3'd1);
            end
            if (state_reg == ST_CMP_HEAD)
            begin
                steps_reg <= '0;
            end
            // chain walk frees one link a cycle
            if (state_reg == ST_WALK)
            begin
                free_map_reg[cur_reg] <= 1'b1;
                steps_reg             <= steps_reg + IDX_W'(1);
                if (walk_end)
                begin
                    pend_rptr_reg  <= pend_rptr_reg + IDX_W'(1);
                    pend_total_reg <= pend_total_reg - PEND_CNT_W'(1);
                end
            end
        end
    end

    // item payload and walk pointers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wr_reg        <= write_req;
            data_addr_reg <= data_addr;
            used_id_reg   <= used_id;
            io_err_reg    <= (io_status != 8'd0);
            d0_reg        <= alloc_d0;
            d1_reg        <= alloc_d1;
            d2_reg        <= alloc_d2;
            haddr_reg     <= header_base_reg
                             + 64'(11'(alloc_d0) * 11'(header_stride_reg));
            saddr_reg     <= status_base_reg
                             + 64'(11'(alloc_d0) * 11'(status_stride_reg));
            sector_reg    <= 64'(block_number) * 64'(SECT_PER_BLK);
            reply_kind_reg <= KIND_NO_FREE;
            reply_di_reg   <= '0;
        end
        if (state_reg == ST_CMP_HEAD)
        begin
            head_reg <= pend_rdata;
            cur_reg  <= pend_rdata;
            if (pend_total_reg == '0)
            begin
                reply_kind_reg <= KIND_UNEXPECTED;
                reply_di_reg   <= '0;
            end
            else
            begin
                reply_kind_reg <= KIND_UNEXPECTED;
                reply_di_reg   <= pend_rdata;
            end
        end
        if (state_reg == ST_WALK)
        begin
            cur_reg <= chain_rdata.next;
            if (walk_end)
            begin
                reply_kind_reg <= io_err_reg ? KIND_IO_ERROR : KIND_OK;
                reply_di_reg   <= head_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= gen_word;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_word_reg.kind;
    assign desc_index  = out_word_reg.desc_index;
    assign addr        = out_word_reg.addr;
    assign length      = out_word_reg.length;
    assign flags       = out_word_reg.flags;
    assign next_index  = out_word_reg.next_index;
    assign header_type = out_word_reg.header_type;
    assign sector      = out_word_reg.sector;
    assign ring_slot   = out_word_reg.ring_slot;
    assign ring_index  = out_word_reg.ring_index;
    assign last        = out_word_reg.last;

    // every outstanding request holds exactly three descriptors when idle
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            ($countones(~free_map_reg) == CHAIN_LEN * int'(pend_total_reg)))
        else $error("free map disagrees with outstanding count");

    // the queue can never hold more chains than descriptors allow
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_total_reg <= PEND_CNT_W'(RING_ENTRIES / CHAIN_LEN))
        else $error("outstanding count beyond descriptor capacity");

    // chain links are only written while a submission is being emitted
    a_chain_write: assert property (@(posedge clk) disable iff (!rst_n)
        chain_we |-> (state_reg == ST_SUB))
        else $error("chain memory written outside a submission");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted while an item is in progress");

endmodule

// ===== sim/tb_virtqueue_block_request_engine.sv =====
// tb_virtqueue_block_request_engine: self-checking bench for the virtqueue block request engine
// drives submit and completion words, predicts every result word and compares them in order
// depends on vcq_pkg and the rtl top level virtqueue_block_request_engine
`timescale 1ns / 100ps

module tb_virtqueue_block_request_engine;

    import vcq_pkg::*;

    localparam int  SECTORS_PER_BLOCK = BLOCK_BYTES_DEF / SECTOR_BYTES;
    localparam int  WATCHDOG_LIMIT    = 3000;
    localparam int  PHASE_ITEMS       = 60;
    localparam int  LONG_HOLD         = 300;

    // one input word
    typedef struct packed {
        logic        req;
        logic        wr;
        logic [31:0] blk;
        logic [63:0] daddr;
        logic [31:0] uid;
        logic [7:0]  ios;
    } item_t;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  idx;
        logic [63:0] addr;
        logic [31:0] len;
        logic [1:0]  fl;
        logic [2:0]  nx;
        logic        ht;
        logic [63:0] sec;
        logic [2:0]  slot;
        logic [15:0] ridx;
        logic        lst;
    } word_t;

    // directed row, with an optional hand-typed single result word
    typedef struct packed {
        item_t       it;
        logic        typed;
        kind_t       kind;
        logic [2:0]  idx;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   req_type = 1'b0;
    logic                   write_req = 1'b0;
    logic [31:0]            block_number = '0;
    logic [63:0]            data_addr = '0;
    logic [31:0]            used_id = '0;
    logic [7:0]             io_status = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    kind_t                  out_kind;
    logic [IDX_W-1:0]       desc_index;
    logic [63:0]            addr;
    logic [31:0]            length;
    logic [1:0]             flags;
    logic [IDX_W-1:0]       next_index;
    logic                   header_type;
    logic [63:0]            sector;
    logic [IDX_W-1:0]       ring_slot;
    logic [15:0]            ring_index;
    logic                   last;

    virtqueue_block_request_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .write_req    (write_req),
        .block_number (block_number),
        .data_addr    (data_addr),
        .used_id      (used_id),
        .io_status    (io_status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .desc_index   (desc_index),
        .addr         (addr),
        .length       (length),
        .flags        (flags),
        .next_index   (next_index),
        .header_type  (header_type),
        .sector       (sector),
        .ring_slot    (ring_slot),
        .ring_index   (ring_index),
        .last         (last)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // queue shadow: descriptor map, chain links, rings, outstanding heads
    logic        desc_free [RING_ENTRIES];
    logic [1:0]  link_flags [RING_ENTRIES];
    logic [2:0]  link_next [RING_ENTRIES];
    logic [15:0] avail_idx;
    logic [15:0] done_ring_cnt;
    logic [2:0]  heads_q [RING_ENTRIES];
    int          heads_cnt;
    logic [2:0]  heads_rd;
    logic [2:0]  heads_wr;

    // register shadow
    logic [63:0] hdr_base;
    logic [63:0] hdr_stride;
    logic [63:0] sts_base;
    logic [63:0] sts_stride;

    word_t       due_words [$];
    row_t        plan_rows [$];

    int          mismatches = 0;
    int          words_done = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          settings_used = 1;
    int          chains_built = 0;
    int          no_free_cnt = 0;
    int          ok_cnt = 0;
    int          ioerr_cnt = 0;
    int          unexp_cnt = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            mismatches++;
            $display("mismatch at word %0d: %s got %0h want %0h",
                     words_done, what, got, want);
        end
    endtask

    function automatic word_t plain_word(input kind_t k, input logic [2:0] di,
                                         input logic lst);
        word_t w;
        begin
            w = '0;
            w.kind = k;
            w.idx = di;
            w.lst = lst;
            return w;
        end
    endfunction

    task automatic shadow_reset();
        begin
            for (int i = 0; i < RING_ENTRIES; i++)
            begin
                desc_free[i] = 1'b1;
                link_flags[i] = '0;
                link_next[i] = '0;
                heads_q[i] = '0;
            end
            avail_idx = '0;
            done_ring_cnt = '0;
            heads_cnt = 0;
            heads_rd = '0;
            heads_wr = '0;
            hdr_base = '0;
            hdr_stride = 64'd16;
            sts_base = '0;
            sts_stride = 64'd16;
        end
    endtask

    // works out the result words of one accepted input word and updates the shadow
    task automatic chain_step(input item_t it);
        logic [2:0]  d [3];
        int          n;
        word_t       w;
        logic [1:0]  f1;
        logic [63:0] haddr;
        logic [63:0] saddr;
        logic [2:0]  head;
        logic [2:0]  cur;
        logic [1:0]  fl;
        logic        walking;
        begin
            if (it.req == REQ_SUBMIT)
            begin
                // lowest three free descriptors
                n = 0;
                for (int i = 0; i < RING_ENTRIES; i++)
                begin
                    if (desc_free[i] && n < CHAIN_LEN)
                    begin
                        d[n] = 3'(i);
                        n++;
                    end
                end
                if (n < CHAIN_LEN || heads_cnt >= RING_ENTRIES)
                begin
                    due_words.push_back(plain_word(KIND_NO_FREE, 3'd0, 1'b1));
                    no_free_cnt++;
                end
                else
                begin
                    haddr = hdr_base + 64'(d[0]) * hdr_stride;
                    saddr = sts_base + 64'(d[0]) * sts_stride;
                    f1 = it.wr ? F_NEXT : (F_NEXT | F_DEVWR);
                    for (int i = 0; i < CHAIN_LEN; i++)
                        desc_free[d[i]] = 1'b0;
                    link_flags[d[0]] = F_NEXT;
                    link_next[d[0]] = d[1];
                    link_flags[d[1]] = f1;
                    link_next[d[1]] = d[2];
                    link_flags[d[2]] = F_DEVWR;
                    link_next[d[2]] = '0;

                    w = plain_word(KIND_HEADER, d[0], 1'b0);
                    w.addr = haddr;
                    w.ht = it.wr;
                    w.sec = 64'(it.blk) * 64'(SECTORS_PER_BLOCK);
                    due_words.push_back(w);

                    w = plain_word(KIND_DESC, d[0], 1'b0);
                    w.addr = haddr;
                    w.len = 32'(HDR_BYTES);
                    w.fl = F_NEXT;
                    w.nx = d[1];
                    due_words.push_back(w);

                    w = plain_word(KIND_DESC, d[1], 1'b0);
                    w.addr = it.daddr;
                    w.len = 32'(BLOCK_BYTES_DEF);
                    w.fl = f1;
                    w.nx = d[2];
                    due_words.push_back(w);

                    w = plain_word(KIND_DESC, d[2], 1'b0);
                    w.addr = saddr;
                    w.len = 32'd1;
                    w.fl = F_DEVWR;
                    due_words.push_back(w);

                    w = plain_word(KIND_STATUS, d[0], 1'b0);
                    w.addr = saddr;
                    due_words.push_back(w);

                    w = plain_word(KIND_AVAIL, d[0], 1'b0);
                    w.slot = avail_idx[2:0];
                    w.ridx = avail_idx + 16'd1;
                    due_words.push_back(w);

                    due_words.push_back(plain_word(KIND_NOTIFY, d[0], 1'b1));

                    avail_idx = avail_idx + 16'd1;
                    heads_q[heads_wr] = d[0];
                    heads_wr = heads_wr + 3'd1;
                    heads_cnt++;
                    chains_built++;
                end
            end
            else if (heads_cnt == 0)
            begin
                due_words.push_back(plain_word(KIND_UNEXPECTED, 3'd0, 1'b1));
                unexp_cnt++;
            end
            else
            begin
                head = heads_q[heads_rd];
                if (it.uid != 32'(head))
                begin
                    due_words.push_back(plain_word(KIND_UNEXPECTED, head, 1'b1));
                    unexp_cnt++;
                end
                else
                begin
                    // free the chain along the stored links
                    cur = head;
                    walking = 1'b1;
                    for (int s = 0; s < RING_ENTRIES; s++)
                    begin
                        if (walking)
                        begin
                            fl = link_flags[cur];
                            desc_free[cur] = 1'b1;
                            link_flags[cur] = '0;
                            walking = fl[0];
                            cur = link_next[cur];
                        end
                    end
                    for (int i = 0; i < RING_ENTRIES; i++)
                        if (desc_free[i])
                            link_next[i] = '0;
                    done_ring_cnt = done_ring_cnt + 16'd1;
                    heads_rd = heads_rd + 3'd1;
                    heads_cnt--;
                    if (it.ios == 8'd0)
                    begin
                        due_words.push_back(plain_word(KIND_OK, head, 1'b1));
                        ok_cnt++;
                    end
                    else
                    begin
                        due_words.push_back(plain_word(KIND_IO_ERROR, head, 1'b1));
                        ioerr_cnt++;
                    end
                end
            end
        end
    endtask

    // holds the word on the input channel until it is taken, then predicts it
    task automatic offer(input item_t it);
        begin
            req_type <= it.req;
            write_req <= it.wr;
            block_number <= it.blk;
            data_addr <= it.daddr;
            used_id <= it.uid;
            io_status <= it.ios;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            chain_step(it);
            items_sent++;
        end
    endtask

    // drops valid and waits for every predicted word to come out
    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (due_words.size() != 0)
                @(posedge clk);
        end
    endtask

    // writes all four registers on consecutive cycles, junk above the stride bits
    task automatic apply_config(input logic [63:0] hb, input logic [7:0] hs,
                                input logic [63:0] sb, input logic [7:0] ss);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_HEADER_BASE;
            cfg_data <= hb;
            @(posedge clk);
            cfg_index <= CFG_HEADER_STRIDE;
            cfg_data <= {24'($urandom), 32'($urandom), hs};
            @(posedge clk);
            cfg_index <= CFG_STATUS_BASE;
            cfg_data <= sb;
            @(posedge clk);
            cfg_index <= CFG_STATUS_STRIDE;
            cfg_data <= {24'($urandom), 32'($urandom), ss};
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            hdr_base = hb;
            hdr_stride = 64'(hs);
            sts_base = sb;
            sts_stride = 64'(ss);
            settings_used++;
        end
    endtask

    task automatic add_row(input logic req, input logic wr, input logic [31:0] blk,
                           input logic [63:0] daddr, input logic [31:0] uid,
                           input logic [7:0] ios, input logic typed, input kind_t k,
                           input logic [2:0] di);
        row_t r;
        begin
            r.it = '{req: req, wr: wr, blk: blk, daddr: daddr, uid: uid, ios: ios};
            r.typed = typed;
            r.kind = k;
            r.idx = di;
            plan_rows.push_back(r);
        end
    endtask

    // random word, mostly well-formed against the outstanding heads
    task automatic choose_item(output item_t it);
        int         r;
        logic [2:0] head;
        begin
            r = $urandom_range(0, 99);
            it.req = REQ_SUBMIT;
            it.wr = 1'($urandom);
            it.blk = $urandom;
            it.daddr = {$urandom, $urandom};
            it.uid = $urandom;
            it.ios = 8'($urandom);
            if (heads_cnt == 0)
            begin
                if (r < 7)
                    it.req = REQ_COMPLETE;
            end
            else
            begin
                head = heads_q[heads_rd];
                if (r < (heads_cnt >= 2 ? 85 : 50))
                begin
                    it.req = REQ_COMPLETE;
                    if (r >= (heads_cnt >= 2 ? 75 : 45))
                    begin
                        // wrong head: either another index or a random id
                        if (r % 2 == 0)
                            it.uid = 32'(head ^ 3'd3);
                    end
                    else
                    begin
                        it.uid = 32'(head);
                        it.ios = (r % 4 == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
                    end
                end
            end
        end
    endtask

    // result word check against the oldest prediction
    task automatic check_word();
        word_t want;
        begin
            if (due_words.size() == 0)
                report_mismatch("word with nothing outstanding", 64'(out_kind), 64'd0);
            else
            begin
                want = due_words.pop_front();
                if (out_kind !== want.kind)
                    report_mismatch("out_kind", 64'(out_kind), 64'(want.kind));
                if (desc_index !== want.idx)
                    report_mismatch("desc_index", 64'(desc_index), 64'(want.idx));
                if (addr !== want.addr)
                    report_mismatch("addr", addr, want.addr);
                if (length !== want.len)
                    report_mismatch("length", 64'(length), 64'(want.len));
                if (flags !== want.fl)
                    report_mismatch("flags", 64'(flags), 64'(want.fl));
                if (next_index !== want.nx)
                    report_mismatch("next_index", 64'(next_index), 64'(want.nx));
                if (header_type !== want.ht)
                    report_mismatch("header_type", 64'(header_type), 64'(want.ht));
                if (sector !== want.sec)
                    report_mismatch("sector", sector, want.sec);
                if (ring_slot !== want.slot)
                    report_mismatch("ring_slot", 64'(ring_slot), 64'(want.slot));
                if (ring_index !== want.ridx)
                    report_mismatch("ring_index", 64'(ring_index), 64'(want.ridx));
                if (last !== want.lst)
                    report_mismatch("last", 64'(last), 64'(want.lst));
            end
            words_done++;
        end
    endtask

    // output monitor and watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
            check_word();
    end

    // receiver: rotating stall patterns plus two long hold-offs
    initial
    begin
        int cyc;
        int holds;
        cyc = 0;
        holds = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (holds < 2 && words_done >= (holds == 0 ? 120 : 600))
            begin
                out_ready <= 1'b0;
                holds++;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end
            else
            begin
                case ((cyc / 97) % 3)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (cyc % 4 == 0);
                endcase
            end
        end
    end

    // sender and run control
    initial
    begin
        item_t      it;
        int         burst_left;
        logic [63:0] hb;
        logic [63:0] sb;
        logic [7:0]  hs;
        logic [7:0]  ss;

        shadow_reset();

        // directed rows; typed rows carry one word each
        add_row(REQ_COMPLETE, 1'b1, 32'hffff_ffff, '1, 32'd0, 8'd0, 1'b1, KIND_UNEXPECTED, 3'd0);
        add_row(REQ_SUBMIT, 1'b0, 32'd0, 64'd0, 32'hffff_ffff, 8'hff, 1'b0, KIND_DESC, 3'd0);
        add_row(REQ_SUBMIT, 1'b1, 32'hffff_ffff, '1, 32'd0, 8'd0, 1'b0, KIND_DESC, 3'd0);
        add_row(REQ_SUBMIT, 1'b1, 32'h1234_5678, 64'h1000, 32'd0, 8'd0, 1'b1,
                KIND_NO_FREE, 3'd0);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd3, 8'd0, 1'b1, KIND_UNEXPECTED, 3'd0);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd8, 8'd0, 1'b1, KIND_UNEXPECTED, 3'd0);
        add_row(REQ_COMPLETE, 1'b1, 32'd0, 64'd0, 32'hffff_ffff, 8'd0, 1'b1,
                KIND_UNEXPECTED, 3'd0);
        add_row(REQ_COMPLETE, 1'b1, 32'hffff_ffff, '1, 32'd0, 8'd0, 1'b1, KIND_OK, 3'd0);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd3, 8'hff, 1'b1, KIND_IO_ERROR, 3'd3);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd3, 8'd0, 1'b1, KIND_UNEXPECTED, 3'd0);
        add_row(REQ_SUBMIT, 1'b1, 32'd1, 64'h8000_0000_0000_0001, 32'd5, 8'h7f, 1'b0,
                KIND_DESC, 3'd0);
        add_row(REQ_SUBMIT, 1'b0, 32'h8000_0000, 64'h5555_5555_5555_5555, 32'd0, 8'd0, 1'b0,
                KIND_DESC, 3'd0);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd0, 8'd1, 1'b1, KIND_IO_ERROR, 3'd0);
        add_row(REQ_SUBMIT, 1'b0, 32'h7fff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 32'd0, 8'd0, 1'b0,
                KIND_DESC, 3'd0);
        add_row(REQ_SUBMIT, 1'b0, 32'd2, 64'h2000, 32'd0, 8'd0, 1'b1, KIND_NO_FREE, 3'd0);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd0, 8'd0, 1'b1, KIND_UNEXPECTED, 3'd3);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd3, 8'h80, 1'b1, KIND_IO_ERROR, 3'd3);
        add_row(REQ_COMPLETE, 1'b0, 32'd0, 64'd0, 32'd0, 8'd0, 1'b1, KIND_OK, 3'd0);
        add_row(REQ_SUBMIT, 1'b1, 32'hdead_beef, 64'h0123_4567_89ab_cdef, 32'd0, 8'd0, 1'b0,
                KIND_DESC, 3'd0);
        add_row(REQ_COMPLETE, 1'b1, 32'd0, 64'd0, 32'd0, 8'd0, 1'b1, KIND_OK, 3'd0);

        // hold reset, then release it
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset register values
        foreach (plan_rows[i])
        begin
            offer(plan_rows[i].it);
            if (plan_rows[i].typed)
                due_words[due_words.size() - 1] =
                    plain_word(plan_rows[i].kind, plan_rows[i].idx, 1'b1);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < 4; p++)
        begin
            drain();
            repeat (8)
                @(posedge clk);
            case (p)
                0:
                begin
                    hb = '1;
                    hs = 8'd255;
                    sb = 64'hffff_ffff_ffff_fff0;
                    ss = 8'd255;
                end
                1:
                begin
                    hb = '0;
                    hs = 8'd1;
                    sb = '0;
                    ss = 8'd1;
                end
                2:
                begin
                    hb = {$urandom, $urandom};
                    hs = 8'($urandom_range(1, 255));
                    sb = {$urandom, $urandom};
                    ss = 8'($urandom_range(1, 255));
                end
                default:
                begin
                    hb = 64'h0000_8000_0000_0000;
                    hs = 8'd16;
                    sb = 64'h1000;
                    ss = 8'd200;
                end
            endcase
            apply_config(hb, hs, sb, ss);

            burst_left = $urandom_range(1, 8);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                choose_item(it);
                offer(it);
                // first phase runs back to back; the rest in bursts with gaps
                if (p != 0)
                begin
                    burst_left--;
                    if ($urandom_range(0, 49) == 0)
                    begin
                        drain();
                        burst_left = $urandom_range(1, 8);
                    end
                    else if (burst_left == 0)
                    begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 6))
                            @(posedge clk);
                        burst_left = $urandom_range(1, 8);
                    end
                end
            end
        end

        // wait out the last words and a short tail
        drain();
        repeat (20)
            @(posedge clk);

        $display("run: %0d words in, %0d chains built, %0d no-free, %0d ok, %0d io error, %0d unexpected",
                 items_sent, chains_built, no_free_cnt, ok_cnt, ioerr_cnt, unexp_cnt);
        $display("%0d result words checked over %0d register settings, %0d mismatches",
                 words_done, settings_used, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
